### design/assert_macros.svh
// Assertion macros shared by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

### design/pasv_pkg.sv
// Constants shared by the PASV reply parser and its channel interfaces.
package pasv_pkg;
	localparam int CHAR_W  = 8;
	localparam int IP_W    = 32;
	localparam int PORT_W  = 16;
	localparam int GROUP_W = 10;
	localparam int OCTET_W = 8;

	localparam int PORT_SHIFT = 8;

	localparam logic [2:0] PH_SEEK   = 3'd0;
	localparam logic [2:0] PH_GROUPS = 3'd1;
	localparam logic [2:0] PH_TAIL   = 3'd2;
	localparam logic [2:0] PH_FAIL   = 3'd3;

	localparam logic [2:0] LAST_GROUP = 3'd5;
	localparam logic [1:0] MAX_DIGITS = 2'd3;

	localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
	localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;
	localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
endpackage

### design/pasv_if.sv
// Valid/ready channels for reply characters and parse results.
interface pasv_char_if
	import pasv_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_byte;
	logic              line_end;

	modport source (output valid, char_byte, line_end, input ready);
	modport sink (input valid, char_byte, line_end, output ready);
endinterface

interface pasv_result_if
	import pasv_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic              ok;
	logic [IP_W-1:0]   ip_address;
	logic [PORT_W-1:0] port_number;

	modport source (output valid, ok, ip_address, port_number, input ready);
	modport sink (input valid, ok, ip_address, port_number, output ready);
endinterface

### design/pasv_reply_address_parser.sv
// PASV reply line parser: host address and data port from "(h1,h2,h3,h4,p1,p2)".
//
// Usage:
//   chars  : one reply character per transfer, line_end set on the final one.
//   result : one transfer per line, sent after the character with line_end;
//            ok, ip_address and port_number (address and port are 0 when ok is 0).
// Bytes before the first '(' are skipped; six comma-separated groups of 1-3
// digits and a ')' must follow, then any bytes but CR and LF.
// Datapath: a character is captured in an input register, then parsed
// combinationally against the state registers; when the final character
// leaves the input register, the result register is loaded and
// result.valid rises; a result still waiting in it can stall that load.
// Throughput is one character per cycle, set by the single parse stage, except while a final character waits.
// Reset clears the parse state and the valid bits of both registers; the next line starts fresh.
// Stall: while a result waits in the output register, ordinary characters
// keep flowing; only a second final character holds in the input register,
// and chars.ready drops until the result is taken.
module pasv_reply_address_parser
	import pasv_pkg::*;
	(
	input  logic                 clk,
	input  logic                 arst_n,
	pasv_char_if.sink            chars,
	pasv_result_if.source        result
);
`include "assert_macros.svh"

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;

	logic [2:0]         phase_q;
	logic [2:0]         group_index_q;
	logic [1:0]         digit_count_q;
	logic [GROUP_W-1:0] group_value_q;
	logic [OCTET_W-1:0] octets_q [4];
	logic               overflow_q;
	logic [GROUP_W-1:0] port_high_q;

	logic              out_valid_q;
	logic              ok_q;
	logic [IP_W-1:0]   ip_q;
	logic [PORT_W-1:0] port_q;

	logic out_free;
	logic advance;

	logic [2:0]         phase_n;
	logic [2:0]         group_index_n;
	logic [1:0]         digit_count_n;
	logic [GROUP_W-1:0] group_value_n;
	logic               overflow_n;
	logic               store_octet;
	logic               store_port_high;
	logic               is_digit;
	logic [GROUP_W-1:0] digit_val;
	logic               good;

	assign out_free    = !out_valid_q || result.ready;
	assign advance     = valid_s1 && (!last_s1 || out_free);
	assign chars.ready = !valid_s1 || advance;

	assign is_digit  = (char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE);
	assign digit_val = GROUP_W'(char_s1 - CH_ZERO);

	always_comb begin
		phase_n         = phase_q;
		group_index_n   = group_index_q;
		digit_count_n   = digit_count_q;
		group_value_n   = group_value_q;
		overflow_n      = overflow_q;
		store_octet     = 1'b0;
		store_port_high = 1'b0;
		unique case (phase_q)
			PH_SEEK: begin
				if (char_s1 == CH_OPEN) phase_n = PH_GROUPS;
			end
			PH_GROUPS: begin
				priority if (is_digit) begin
					if (digit_count_q == MAX_DIGITS) begin
						phase_n = PH_FAIL;
					end else begin
						group_value_n = GROUP_W'(group_value_q * GROUP_W'(10) + digit_val);
						digit_count_n = digit_count_q + 2'd1;
					end
				end else if (char_s1 == CH_COMMA) begin
					if (digit_count_q == 2'd0 || group_index_q >= LAST_GROUP) begin
						phase_n = PH_FAIL;
					end else begin
						// first four groups are address octets, the fifth is the port high part
						if (!group_index_q[2]) begin
							store_octet = 1'b1;
							if (|group_value_q[GROUP_W-1:OCTET_W]) overflow_n = 1'b1;
						end else begin
							store_port_high = 1'b1;
						end
						group_index_n = group_index_q + 3'd1;
						digit_count_n = 2'd0;
						group_value_n = '0;
					end
				end else if (char_s1 == CH_CLOSE) begin
					if (digit_count_q == 2'd0 || group_index_q != LAST_GROUP) phase_n = PH_FAIL;
					else phase_n = PH_TAIL;
				end else begin
					phase_n = PH_FAIL;
				end
			end
			PH_TAIL: begin
				if (char_s1 == CH_CR || char_s1 == CH_LF) phase_n = PH_FAIL;
			end
			default: ;
		endcase
	end

	assign good = (phase_n == PH_TAIL) && !overflow_n;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.char_byte;
			last_s1 <= chars.line_end;
		end
	end

	// parse state; clear after the final character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_SEEK;
			group_index_q <= '0;
			digit_count_q <= '0;
			group_value_q <= '0;
			overflow_q    <= 1'b0;
			port_high_q   <= '0;
			for (int i = 0; i < 4; i++) octets_q[i] <= '0;
		end else if (advance) begin
			if (last_s1) begin
				phase_q       <= PH_SEEK;
				group_index_q <= '0;
				digit_count_q <= '0;
				group_value_q <= '0;
				overflow_q    <= 1'b0;
				port_high_q   <= '0;
				for (int i = 0; i < 4; i++) octets_q[i] <= '0;
			end else begin
				phase_q       <= phase_n;
				group_index_q <= group_index_n;
				digit_count_q <= digit_count_n;
				group_value_q <= group_value_n;
				overflow_q    <= overflow_n;
				if (store_octet) octets_q[group_index_q[1:0]] <= group_value_q[OCTET_W-1:0];
				if (store_port_high) port_high_q <= group_value_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			ok_q <= good;
			if (good) begin
				ip_q   <= {octets_q[0], octets_q[1], octets_q[2], octets_q[3]};
				port_q <= {port_high_q[PORT_W-PORT_SHIFT-1:0], PORT_SHIFT'(0)}
					| PORT_W'(group_value_n);
			end else begin
				ip_q   <= '0;
				port_q <= '0;
			end
		end
	end

	assign result.valid       = out_valid_q;
	assign result.ok          = ok_q;
	assign result.ip_address  = ip_q;
	assign result.port_number = port_q;

	`ASSERT_IMPL(a_fail_zero, clk, arst_n, result.valid && !result.ok,
		result.ip_address == '0 && result.port_number == '0)
	`ASSERT_IMPL(a_group_range, clk, arst_n, 1'b1, group_index_q <= LAST_GROUP)
	`ASSERT_IMPL(a_empty_group, clk, arst_n, digit_count_q == 2'd0, group_value_q == '0)
	`ASSERT_NEXT(a_result_load, clk, arst_n, advance && last_s1, out_valid_q)
endmodule
